// ===== hw/rtl/timecode_to_rational_time_top_macros.svh =====
// Assertion macros for the timecode converter; they expect clk and rst_n in scope.
`ifndef TIMECODE_TO_RATIONAL_TIME_TOP_MACROS_SVH
`define TIMECODE_TO_RATIONAL_TIME_TOP_MACROS_SVH

// Same-cycle implication.
`define TCRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tcrt_pkg.sv =====
// Types, rate codes and coefficient table for the timecode converter.
package tcrt_pkg;

  localparam logic [3:0] RC_24    = 4'd1;
  localparam logic [3:0] RC_24_B  = 4'd2;
  localparam logic [3:0] RC_25    = 4'd3;
  localparam logic [3:0] RC_29_97 = 4'd4;
  localparam logic [3:0] RC_30    = 4'd5;
  localparam logic [3:0] RC_50    = 4'd6;
  localparam logic [3:0] RC_59_94 = 4'd7;
  localparam logic [3:0] RC_60    = 4'd8;

  localparam logic [15:0] ERR_SCALE = 16'd1;
  localparam logic [10:0] DROP_TEN_MIN_K = 11'd2000;

  typedef struct packed {
    logic [4:0]        hours;
    logic [5:0]        minutes;
    logic [5:0]        seconds;
    logic [5:0]        frame_count;
    logic signed [7:0] frame_adjust;
    logic              half_frame;
    logic [3:0]        rate_code;
    logic              drop_mode;
  } tcrt_in_t;

  typedef struct packed {
    logic signed [31:0] time_value;
    logic [15:0]        time_scale;
    logic               bad_rate;
  } tcrt_out_t;

  // Per-field weights, already scaled by 1000.
  typedef struct packed {
    logic [27:0] kh;
    logic [21:0] km;
    logic [10:0] kd;
    logic [15:0] ks;
    logic [15:0] scale;
    logic        bad;
  } tcrt_coef_t;

  function automatic tcrt_coef_t tcrt_coef(input logic [3:0] code, input logic drop);
    tcrt_coef_t c;
    c = '{kh: '0, km: '0, kd: '0, ks: '0, scale: ERR_SCALE, bad: 1'b1};
    unique case (code)
      RC_24: begin
        c = drop ? '{28'd86292000, 22'd1438000, DROP_TEN_MIN_K, 16'd24000, 16'd24000, 1'b0}
                 : '{28'd86400000, 22'd1440000, 11'd0, 16'd24000, 16'd24000, 1'b0};
      end
      RC_24_B:  c = '{28'd86400000, 22'd1440000, 11'd0, 16'd24000, 16'd24000, 1'b0};
      RC_25:    c = '{28'd90000000, 22'd1500000, 11'd0, 16'd25000, 16'd25000, 1'b0};
      RC_29_97: begin
        c = drop ? '{28'd107892000, 22'd1798000, DROP_TEN_MIN_K, 16'd30000, 16'd29970, 1'b0}
                 : '{28'd108000000, 22'd1800000, 11'd0, 16'd30000, 16'd29970, 1'b0};
      end
      RC_30:    c = '{28'd108000000, 22'd1800000, 11'd0, 16'd30000, 16'd30000, 1'b0};
      RC_50:    c = '{28'd180000000, 22'd3000000, 11'd0, 16'd50000, 16'd50000, 1'b0};
      RC_59_94: begin
        c = drop ? '{28'd215892000, 22'd3598000, DROP_TEN_MIN_K, 16'd60000, 16'd59940, 1'b0}
                 : '{28'd216000000, 22'd3600000, 11'd0, 16'd60000, 16'd59940, 1'b0};
      end
      RC_60:    c = '{28'd216000000, 22'd3600000, 11'd0, 16'd60000, 16'd60000, 1'b0};
      default:  c = '{kh: '0, km: '0, kd: '0, ks: '0, scale: ERR_SCALE, bad: 1'b1};
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/tcrt_in_if.sv =====
// Timecode request channel.
interface tcrt_in_if;
  logic              valid;
  logic              ready;
  tcrt_pkg::tcrt_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/tcrt_out_if.sv =====
// Frame-time result channel.
interface tcrt_out_if;
  logic               valid;
  logic               ready;
  tcrt_pkg::tcrt_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/tcrt_in_stage.sv =====
// Input register stage for timecode requests.
module tcrt_in_stage (
  input  logic        clk,
  input  logic        rst_n,
  tcrt_in_if.sink     in_ch,
  tcrt_in_if.source   fwd
);

  logic               vld_r;
  logic               vld_nxt;
  tcrt_pkg::tcrt_in_t pl_r;

  assign in_ch.ready = !vld_r || fwd.ready;
  assign fwd.valid   = vld_r;
  assign fwd.payload = pl_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ch.ready) begin
      vld_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      pl_r <= in_ch.payload;
    end
  end

endmodule

// ===== hw/rtl/tcrt_calc_stage.sv =====
// Frame-time arithmetic and result register.
module tcrt_calc_stage (
  input  logic        clk,
  input  logic        rst_n,
  tcrt_in_if.sink     fwd,
  tcrt_out_if.source  out_ch
);

  tcrt_pkg::tcrt_in_t   p;
  tcrt_pkg::tcrt_coef_t c;
  logic [13:0]          mn_x205;
  logic [2:0]           mn_div10;
  logic signed [8:0]    fr;
  logic [31:0]          p_h;
  logic [31:0]          p_m;
  logic [31:0]          p_d;
  logic [31:0]          p_s;
  logic [31:0]          p_f;
  logic [31:0]          half_k;
  logic [31:0]          sum;
  tcrt_pkg::tcrt_out_t  res;

  logic                 vld_r;
  logic                 vld_nxt;
  tcrt_pkg::tcrt_out_t  pl_r;

  assign p = fwd.payload;
  assign c = tcrt_pkg::tcrt_coef(p.rate_code, p.drop_mode);

  // minutes / 10 as a reciprocal multiply, exact for 0..63
  assign mn_x205  = 14'(p.minutes) * 14'd205;
  assign mn_div10 = mn_x205[13:11];

  assign fr = $signed({3'b000, p.frame_count}) + $signed({p.frame_adjust[7], p.frame_adjust});

  // All weights are pre-scaled by 1000 so each term is one constant multiply.
  assign p_h    = 32'(p.hours) * 32'(c.kh);
  assign p_m    = 32'(p.minutes) * 32'(c.km);
  assign p_d    = 32'(mn_div10) * 32'(c.kd);
  assign p_s    = 32'(p.seconds) * 32'(c.ks);
  assign p_f    = unsigned'(32'(fr) * 32'sd1000);
  assign half_k = p.half_frame ? 32'd500 : 32'd0;
  assign sum    = p_h + p_m + p_d + p_s + p_f + half_k;

  always_comb begin
    res.time_value = c.bad ? 32'sd0 : signed'(sum);
    res.time_scale = c.scale;
    res.bad_rate   = c.bad;
  end

  assign fwd.ready      = !vld_r || out_ch.ready;
  assign out_ch.valid   = vld_r;
  assign out_ch.payload = pl_r;

  always_comb begin
    vld_nxt = vld_r;
    if (fwd.ready) begin
      vld_nxt = fwd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fwd.ready && fwd.valid) begin
      pl_r <= res;
    end
  end

endmodule

// ===== hw/rtl/timecode_to_rational_time_top.sv =====
// Timecode to frame-time converter, top level.
// Converts one timecode per request into a time in thousandths of a frame plus
// its units-per-second scale. A request is accepted every clock cycle as long as
// the result side keeps taking results. A request goes through one input
// register, then the constant multiply-add tree into the result register.
// Unknown rate codes give value 0, scale 1 and bad_rate set.
`include "timecode_to_rational_time_top_macros.svh"
module timecode_to_rational_time_top (
  input  logic       clk,
  input  logic       rst_n,
  tcrt_in_if.sink    in_ch,
  tcrt_out_if.source out_ch
);

  tcrt_in_if mid ();

  tcrt_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .fwd   (mid.source)
  );

  tcrt_calc_stage u_calc (
    .clk    (clk),
    .rst_n  (rst_n),
    .fwd    (mid.sink),
    .out_ch (out_ch)
  );

  `TCRT_ASSERT_IMP(a_bad_zero, out_ch.valid && out_ch.payload.bad_rate, out_ch.payload.time_value == 32'sd0, "bad rate result has nonzero value")
  `TCRT_ASSERT_IMP(a_bad_scale, out_ch.valid, out_ch.payload.bad_rate == (out_ch.payload.time_scale == tcrt_pkg::ERR_SCALE), "bad_rate and scale disagree")
  `TCRT_ASSERT_NXT(a_advance, mid.valid && mid.ready, out_ch.valid, "accepted request did not reach result register")
  `TCRT_ASSERT_IMP(a_stall, !in_ch.ready, mid.valid && !mid.ready, "input stalled with room in pipeline")

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the timecode to frame-time converter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // rate codes with no converter
  localparam logic [3:0] RC_NONE     = 4'd0;
  localparam logic [3:0] RC_UNUSED_LO = 4'd9;
  localparam logic [3:0] RC_UNUSED_HI = 4'd15;

  localparam int RANDOM_REQS       = 800;
  localparam int QUIET_TAIL_REQS   = 150;
  localparam int PRESSURE_START    = 200;
  localparam int PRESSURE_REQS     = 60;
  localparam int LONG_STALL_CYCLES = 64;

  typedef struct packed {
    tcrt_pkg::tcrt_in_t  tc;
    logic                typed;
    tcrt_pkg::tcrt_out_t res;
  } tc_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tcrt_in_if  in_if();
  tcrt_out_if out_if();

  timecode_to_rational_time_top i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  tcrt_pkg::tcrt_out_t pending_frame_times[$];
  tc_row_t             directed_rows[$];
  tcrt_pkg::tcrt_out_t oldest_frame_time;

  bit idle_on = 1'b1;
  bit source_gaps = 1'b1;
  bit long_stall_wanted = 1'b0;

  int mismatches = 0;
  int timecodes_sent = 0;
  int drop_frame_sent = 0;
  int results_checked = 0;
  int bad_rate_results = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic tcrt_pkg::tcrt_in_t tc(input int hh, input int mm,
                                            input int ss, input int ff,
                                            input int adj, input int half,
                                            input logic [3:0] code, input int drop);
    tcrt_pkg::tcrt_in_t t;
    t.hours        = 5'(hh);
    t.minutes      = 6'(mm);
    t.seconds      = 6'(ss);
    t.frame_count  = 6'(ff);
    t.frame_adjust = 8'(adj);
    t.half_frame   = 1'(half);
    t.rate_code    = code;
    t.drop_mode    = 1'(drop);
    return t;
  endfunction

  function automatic void add_row(input tcrt_pkg::tcrt_in_t t, input logic typed,
                                  input tcrt_pkg::tcrt_out_t res);
    tc_row_t r;
    r.tc    = t;
    r.typed = typed;
    r.res   = res;
    directed_rows.push_back(r);
  endfunction

  // Time in thousandths of a frame plus scale for one timecode.
  function automatic tcrt_pkg::tcrt_out_t frame_time_of(input tcrt_pkg::tcrt_in_t t);
    tcrt_pkg::tcrt_out_t ft;
    logic [31:0] hh, mm, ss, frames, half_units, fps, rate;
    hh = t.hours;
    mm = t.minutes;
    ss = t.seconds;
    frames = {26'd0, t.frame_count} + {{24{t.frame_adjust[7]}}, t.frame_adjust};
    half_units = t.half_frame ? 32'd500 : 32'd0;
    fps = 32'd0;
    rate = 32'd0;
    ft.time_value = '0;
    ft.time_scale = tcrt_pkg::ERR_SCALE;
    ft.bad_rate   = 1'b1;
    unique case (t.rate_code)
      tcrt_pkg::RC_24: begin
        fps = 32'd24;
        rate = 32'd24000;
      end
      tcrt_pkg::RC_24_B:  rate = 32'd24000;
      tcrt_pkg::RC_25:    rate = 32'd25000;
      tcrt_pkg::RC_29_97: begin
        fps = 32'd30;
        rate = 32'd29970;
      end
      tcrt_pkg::RC_30:    rate = 32'd30000;
      tcrt_pkg::RC_50:    rate = 32'd50000;
      tcrt_pkg::RC_59_94: begin
        fps = 32'd60;
        rate = 32'd59940;
      end
      tcrt_pkg::RC_60:    rate = 32'd60000;
      default:            rate = 32'd0;
    endcase
    if (rate == 32'd0) return ft;
    ft.time_scale = rate[15:0];
    ft.bad_rate   = 1'b0;
    if (fps == 32'd0) begin
      ft.time_value = frames * 32'd1000 + (mm * 32'd60 + hh * 32'd3600 + ss) * rate
                      + half_units;
    end else if (t.drop_mode) begin
      // two frame numbers skipped each minute, none on every tenth minute
      ft.time_value = (hh * (fps * 32'd3600 - 32'd108) + mm * (fps * 32'd60 - 32'd2)
                       + (mm / 32'd10) * 32'd2 + ss * fps + frames) * 32'd1000
                      + half_units;
    end else begin
      ft.time_value = mm * (fps * 32'd60000) + hh * (fps * 32'd3600000)
                      + ss * (fps * 32'd1000) + frames * 32'd1000 + half_units;
    end
    return ft;
  endfunction

  function automatic tcrt_pkg::tcrt_in_t random_timecode();
    tcrt_pkg::tcrt_in_t t;
    logic [63:0]        raw;
    if ($urandom_range(0, 9) < 7) begin
      t.rate_code    = 4'($urandom_range(tcrt_pkg::RC_24, tcrt_pkg::RC_60));
      t.hours        = 5'($urandom_range(0, 23));
      t.minutes      = ($urandom_range(0, 3) == 0) ? 6'(10 * $urandom_range(0, 5))
                                                   : 6'($urandom_range(0, 59));
      t.seconds      = 6'($urandom_range(0, 59));
      t.frame_count  = 6'($urandom_range(0, 59));
      t.frame_adjust = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'sd0;
      t.half_frame   = 1'($urandom);
      t.drop_mode    = 1'($urandom);
    end else begin
      raw = {$urandom, $urandom};
      t = raw[$bits(tcrt_pkg::tcrt_in_t)-1:0];
    end
    return t;
  endfunction

  task automatic send_timecode(input tcrt_pkg::tcrt_in_t t, input logic typed,
                               input tcrt_pkg::tcrt_out_t res);
    int gap;
    gap = 0;
    if (source_gaps && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 15);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= t;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_frame_times.push_back(typed ? res : frame_time_of(t));
    timecodes_sent++;
    if (t.drop_mode && (t.rate_code == tcrt_pkg::RC_24 ||
                        t.rate_code == tcrt_pkg::RC_29_97 ||
                        t.rate_code == tcrt_pkg::RC_59_94)) drop_frame_sent++;
  endtask

  // result side: random back-pressure plus one long hold-off on demand
  initial begin
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (long_stall_wanted) begin
        long_stall_wanted = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_frame_times.size() == 0) begin
        $error("result with no request outstanding: value %0d scale %0d bad_rate %0b",
               out_if.payload.time_value, out_if.payload.time_scale,
               out_if.payload.bad_rate);
        mismatches++;
      end else begin
        oldest_frame_time = pending_frame_times.pop_front();
        results_checked++;
        if (out_if.payload.bad_rate) bad_rate_results++;
        if (out_if.payload.time_value !== oldest_frame_time.time_value) begin
          $error("time_value: expected %0d, got %0d",
                 oldest_frame_time.time_value, out_if.payload.time_value);
          mismatches++;
        end
        if (out_if.payload.time_scale !== oldest_frame_time.time_scale) begin
          $error("time_scale: expected %0d, got %0d",
                 oldest_frame_time.time_scale, out_if.payload.time_scale);
          mismatches++;
        end
        if (out_if.payload.bad_rate !== oldest_frame_time.bad_rate) begin
          $error("bad_rate: expected %0b, got %0b",
                 oldest_frame_time.bad_rate, out_if.payload.bad_rate);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.payload = '0;

    // first row right after reset, then error codes and simple extremes
    add_row(tc(0, 0, 0, 0, 0, 0, tcrt_pkg::RC_24, 0), 1'b1, {32'd0, 16'd24000, 1'b0});
    add_row(tc(0, 0, 0, 0, 0, 0, RC_NONE, 0), 1'b1,
            {32'd0, tcrt_pkg::ERR_SCALE, 1'b1});
    add_row(tc(31, 63, 63, 63, -1, 1, RC_UNUSED_LO, 1), 1'b1,
            {32'd0, tcrt_pkg::ERR_SCALE, 1'b1});
    add_row(tc(31, 63, 63, 63, 127, 1, RC_UNUSED_HI, 1), 1'b1,
            {32'd0, tcrt_pkg::ERR_SCALE, 1'b1});
    add_row(tc(0, 0, 0, 0, 0, 1, tcrt_pkg::RC_30, 0), 1'b1, {32'd500, 16'd30000, 1'b0});
    add_row(tc(0, 0, 0, 0, -128, 0, tcrt_pkg::RC_25, 0), 1'b1,
            {-32'sd128000, 16'd25000, 1'b0});
    add_row(tc(0, 0, 1, 0, 0, 0, tcrt_pkg::RC_50, 0), 1'b1, {32'd50000, 16'd50000, 1'b0});
    add_row(tc(0, 0, 0, 1, 0, 0, tcrt_pkg::RC_60, 0), 1'b1, {32'd1000, 16'd60000, 1'b0});
    add_row(tc(0, 0, 0, 0, 0, 0, tcrt_pkg::RC_29_97, 1), 1'b1, {32'd0, 16'd29970, 1'b0});
    add_row(tc(23, 59, 59, 23, 0, 0, tcrt_pkg::RC_24, 1), 1'b0, '0);
    add_row(tc(23, 59, 59, 29, 0, 1, tcrt_pkg::RC_29_97, 1), 1'b0, '0);
    add_row(tc(23, 59, 59, 59, 0, 0, tcrt_pkg::RC_59_94, 1), 1'b0, '0);
    add_row(tc(23, 59, 59, 23, 0, 0, tcrt_pkg::RC_24, 0), 1'b0, '0);
    add_row(tc(23, 59, 59, 29, 0, 0, tcrt_pkg::RC_29_97, 0), 1'b0, '0);
    add_row(tc(23, 59, 59, 59, 0, 1, tcrt_pkg::RC_59_94, 0), 1'b0, '0);
    // drop-frame minute boundaries
    add_row(tc(0, 9, 59, 29, 0, 0, tcrt_pkg::RC_29_97, 1), 1'b0, '0);
    add_row(tc(0, 10, 0, 0, 0, 0, tcrt_pkg::RC_29_97, 1), 1'b0, '0);
    add_row(tc(0, 1, 0, 2, 0, 0, tcrt_pkg::RC_29_97, 1), 1'b0, '0);
    // fields at their top values, frame_adjust at either end, wrapping
    add_row(tc(31, 63, 63, 63, 127, 1, tcrt_pkg::RC_24, 1), 1'b0, '0);
    add_row(tc(31, 63, 63, 63, 127, 1, tcrt_pkg::RC_29_97, 1), 1'b0, '0);
    add_row(tc(31, 63, 63, 63, 127, 1, tcrt_pkg::RC_59_94, 1), 1'b0, '0);
    add_row(tc(31, 63, 63, 63, -128, 1, tcrt_pkg::RC_60, 0), 1'b0, '0);
    // drop flag is ignored outside the three nominal rates; last row: drop set with a negative frame adjust
    add_row(tc(10, 0, 0, 0, 0, 0, tcrt_pkg::RC_25, 1), 1'b0, '0);
    add_row(tc(31, 63, 63, 63, 127, 1, tcrt_pkg::RC_24_B, 1), 1'b0, '0);
    add_row(tc(0, 0, 0, 0, -128, 0, tcrt_pkg::RC_24, 1), 1'b0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_timecode(directed_rows[i].tc, directed_rows[i].typed, directed_rows[i].res);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      idle_on = (n < RANDOM_REQS - QUIET_TAIL_REQS);
      if (n == PRESSURE_START) long_stall_wanted = 1'b1;
      // keep offering requests back to back while the result side holds off
      source_gaps = idle_on && !(n >= PRESSURE_START && n < PRESSURE_START + PRESSURE_REQS);
      send_timecode(random_timecode(), 1'b0, '0);
    end
    in_if.valid <= 1'b0;

    while (pending_frame_times.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Converted %0d timecodes (%0d drop-frame), %0d results compared, %0d bad rate",
             timecodes_sent, drop_frame_sent, results_checked, bad_rate_results);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
